/* rtl/bbk_pkg.sv */
// bbk_pkg: shared types, constants and codes for the best-K keeper.
// Used by bbk_ctrl, bbk_datapath and bounded_best_k_keeper; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bbk_pkg;
  localparam int Depth        = 16;
  localparam int SlotW        = 4;
  localparam int CountW       = 5;
  localparam int KeyW         = 32;
  localparam int PayloadW     = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_REPLACED = 2'd1,
    ST_REJECTED = 2'd2,
    ST_DONE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic start;     // perform first step (append / compare root / clear / read)
    logic up_rd;     // fetch keys for sift-up step
    logic up_cmp;    // compare and maybe swap, sift-up
    logic dn_rd;     // fetch keys for sift-down step
    logic dn_cmp;    // compare and maybe swap, sift-down
    logic out_load;  // present result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_up;
    logic go_down;
    logic step_more;
  } stat_t;
endpackage
`default_nettype wire

/* rtl/bbk_ctrl.sv */
// bbk_ctrl: sequencer for one item at a time through the heap datapath.
// Depends on bbk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bbk_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic          out_busy,
  input  wire bbk_pkg::stat_t st,
  output bbk_pkg::cmd_t      cmd,
  output logic               idle
);
  bbk_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bbk_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    idle       = 1'b0;
    unique case (state)
      bbk_pkg::S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = bbk_pkg::S_START;
        end
      end
      bbk_pkg::S_START: begin
        cmd.start = 1'b1;
        if (st.go_up)        state_next = bbk_pkg::S_UP_RD;
        else if (st.go_down) state_next = bbk_pkg::S_DN_RD;
        else                 state_next = bbk_pkg::S_OUT;
      end
      bbk_pkg::S_UP_RD: begin
        cmd.up_rd  = 1'b1;
        state_next = bbk_pkg::S_UP_CMP;
      end
      bbk_pkg::S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_next = st.step_more ? bbk_pkg::S_UP_RD : bbk_pkg::S_OUT;
      end
      bbk_pkg::S_DN_RD: begin
        cmd.dn_rd  = 1'b1;
        state_next = bbk_pkg::S_DN_CMP;
      end
      bbk_pkg::S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_next = st.step_more ? bbk_pkg::S_DN_RD : bbk_pkg::S_OUT;
      end
      bbk_pkg::S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = bbk_pkg::S_IDLE;
        end
      end
      default: state_next = bbk_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/bbk_datapath.sv */
// bbk_datapath: key/payload stores, heap order array, count and capacity.
// Depends on bbk_pkg; driven by bbk_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module bbk_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire bbk_pkg::cmd_t                    cmd,
  output bbk_pkg::stat_t                        st,
  input  wire logic                             cfg_we,
  input  wire logic [bbk_pkg::CountW-1:0]       cfg_data,
  input  wire logic [1:0]                       in_op,
  input  wire logic [bbk_pkg::KeyW-1:0]         in_key,
  input  wire logic [bbk_pkg::PayloadW-1:0]     in_payload,
  input  wire logic [bbk_pkg::SlotW-1:0]        in_slot,
  output logic [1:0]                            res_status,
  output logic [bbk_pkg::SlotW-1:0]             res_slot,
  output logic [bbk_pkg::CountW-1:0]            res_count,
  output logic [bbk_pkg::KeyW-1:0]              res_key,
  output logic [bbk_pkg::PayloadW-1:0]          res_payload
);
  localparam int SW = bbk_pkg::SlotW;
  localparam int CW = bbk_pkg::CountW;

  logic [bbk_pkg::KeyW-1:0]     key_mem [bbk_pkg::Depth];
  logic [bbk_pkg::PayloadW-1:0] pay_mem [bbk_pkg::Depth];
  logic [SW-1:0]                heap    [bbk_pkg::Depth];

  logic [CW-1:0] capacity, held_count;
  logic [1:0]    op;
  logic [bbk_pkg::KeyW-1:0]     key;
  logic [bbk_pkg::PayloadW-1:0] payload;
  logic [SW-1:0] rslot;
  logic [CW-1:0] pos;        // current heap position (5 bits for child calc)
  logic [SW-1:0] slot_a, slot_b, slot_c;
  logic [bbk_pkg::KeyW-1:0] key_a, key_b, key_c;
  logic          has_l, has_r;
  logic [1:0]    status;
  logic [SW-1:0] wslot;

  logic [CW-1:0] cap_eff;
  logic [SW-1:0] parent;
  logic [CW:0]   lpos, rpos;
  logic [CW:0]   dn_next;
  logic          in_key_lt_root;

  assign cap_eff = (capacity == '0) ? CW'(1) :
                   (capacity > CW'(bbk_pkg::Depth)) ? CW'(bbk_pkg::Depth) : capacity;
  assign parent  = SW'((pos - CW'(1)) >> 1);
  assign lpos    = {pos, 1'b1};
  assign rpos    = {pos, 1'b0} + (CW+1)'(2);
  assign in_key_lt_root = key < key_mem[heap[0]];

  // sift-up swap when parent key < own key; sift-down picks largest, left on ties
  logic          up_swap;
  logic          dn_swap, dn_right;
  always_comb begin
    up_swap  = key_b < key_a;
    dn_right = has_r && (key_c > (has_l && key_b > key_a ? key_b : key_a));
    dn_swap  = (has_l && key_b > key_a) || dn_right;
  end

  assign dn_next = dn_right ? rpos : lpos;

  // sift-down goes on only while the new position still has a left child
  always_comb begin
    st.go_up     = cmd.start && op == bbk_pkg::OP_INSERT && held_count < cap_eff
                   && held_count != '0;
    st.go_down   = cmd.start && op == bbk_pkg::OP_INSERT && !(held_count < cap_eff)
                   && in_key_lt_root;
    st.step_more = cmd.up_cmp ? (up_swap && parent != '0)
                              : (dn_swap && ({dn_next[CW-1:0], 1'b1} < {1'b0, held_count}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CW'(bbk_pkg::Depth);
      held_count <= '0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (cmd.start) begin
        if (op == bbk_pkg::OP_CLEAR) held_count <= '0;
        else if (op == bbk_pkg::OP_INSERT && held_count < cap_eff)
          held_count <= held_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_op;
      key     <= in_key;
      payload <= in_payload;
      rslot   <= in_slot;
    end
    if (cmd.start) begin
      unique case (op)
        bbk_pkg::OP_INSERT: begin
          res_key     <= '0;
          res_payload <= '0;
          if (held_count < cap_eff) begin
            key_mem[held_count[SW-1:0]] <= key;
            pay_mem[held_count[SW-1:0]] <= payload;
            heap[held_count[SW-1:0]]    <= held_count[SW-1:0];
            wslot  <= held_count[SW-1:0];
            status <= bbk_pkg::ST_APPENDED;
            pos    <= held_count;
          end else if (in_key_lt_root) begin
            key_mem[heap[0]] <= key;
            pay_mem[heap[0]] <= payload;
            wslot  <= heap[0];
            status <= bbk_pkg::ST_REPLACED;
            pos    <= '0;
          end else begin
            wslot  <= '0;
            status <= bbk_pkg::ST_REJECTED;
          end
        end
        bbk_pkg::OP_READ: begin
          status      <= bbk_pkg::ST_DONE;
          wslot       <= '0;
          res_key     <= key_mem[rslot];
          res_payload <= pay_mem[rslot];
        end
        default: begin
          status      <= bbk_pkg::ST_DONE;
          wslot       <= '0;
          res_key     <= '0;
          res_payload <= '0;
        end
      endcase
    end
    if (cmd.up_rd) begin
      slot_a <= heap[pos[SW-1:0]];
      slot_b <= heap[parent];
      key_a  <= key_mem[heap[pos[SW-1:0]]];
      key_b  <= key_mem[heap[parent]];
    end
    if (cmd.up_cmp && up_swap) begin
      heap[parent]      <= slot_a;
      heap[pos[SW-1:0]] <= slot_b;
      pos               <= CW'(parent);
    end
    if (cmd.dn_rd) begin
      has_l  <= lpos < {1'b0, held_count};
      has_r  <= rpos < {1'b0, held_count};
      slot_a <= heap[pos[SW-1:0]];
      slot_b <= heap[lpos[SW-1:0]];
      slot_c <= heap[rpos[SW-1:0]];
      key_a  <= key_mem[heap[pos[SW-1:0]]];
      key_b  <= key_mem[heap[lpos[SW-1:0]]];
      key_c  <= key_mem[heap[rpos[SW-1:0]]];
    end
    if (cmd.dn_cmp && dn_swap) begin
      heap[pos[SW-1:0]] <= dn_right ? slot_c : slot_b;
      if (dn_right) begin
        heap[rpos[SW-1:0]] <= slot_a;
        pos <= rpos[CW-1:0];
      end else begin
        heap[lpos[SW-1:0]] <= slot_a;
        pos <= lpos[CW-1:0];
      end
    end
  end

  assign res_status = status;
  assign res_slot   = wslot;
  assign res_count  = held_count;
endmodule
`default_nettype wire

/* rtl/bounded_best_k_keeper.sv */
// bounded_best_k_keeper: top level, stream ports, output register.
// Depends on bbk_pkg, bbk_ctrl and bbk_datapath.
//
// Keeps the capacity entries with the smallest keys in a max-heap of slots.
// s_axis carries one operation item: insert, clear, read or no-op.
// m_axis returns exactly one result item per input item.
// cfg_valid/cfg_ready writes capacity (1..16, reset 16); write only when idle.
// After an item is taken, the start step appends, compares the root,
// clears or reads; each heap step tried then fetches keys and compares
// and maybe swaps. Clear, read, no-op, reject and an append to an empty
// beam try no heap step; any other append tries 1 to 4 sift-up steps, a
// replace 1 to 4 sift-down steps. The result is then loaded into the
// output register and the next item can be taken. One item is worked on
// at a time. The result waits in an output register while m_axis_tready
// is low; the next item is taken meanwhile and holds once its result is due.
// Reset empties the beam and sets capacity to 16; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bounded_best_k_keeper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[1:0], ratio_key[33:2], entry_payload[65:34], read_slot[69:66], zero fill
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], written_slot[5:2], entry_count[10:6], slot_key[42:11],
  // slot_payload[74:43], zero fill
  output logic [79:0]      m_axis_tdata
);
  bbk_pkg::cmd_t  cmd;
  bbk_pkg::stat_t st;
  logic idle, in_fire, out_busy;
  logic [1:0] r_status;
  logic [3:0] r_slot;
  logic [4:0] r_count;
  logic [31:0] r_key, r_pay;

  assign s_axis_tready = idle;
  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_busy      = m_axis_tvalid && !m_axis_tready;

  bbk_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_busy, .st, .cmd, .idle
  );

  bbk_datapath u_dp (
    .clk, .rst, .cmd, .st,
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .in_op       (s_axis_tdata[1:0]),
    .in_key      (s_axis_tdata[33:2]),
    .in_payload  (s_axis_tdata[65:34]),
    .in_slot     (s_axis_tdata[69:66]),
    .res_status  (r_status),
    .res_slot    (r_slot),
    .res_count   (r_count),
    .res_key     (r_key),
    .res_payload (r_pay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load)
      m_axis_tdata <= {5'd0, r_pay, r_key, r_count, r_slot, r_status};
  end
endmodule
`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for bounded_best_k_keeper over its stream ports.
// Depends on bbk_pkg and the RTL; carries its own heap predictor of the beam.
`timescale 1ns / 1ps
module testbench;
  localparam int WatchLimit = 20000;

  // last field in the lowest bits, as on m_axis_tdata
  typedef struct packed {
    logic [31:0] payload;
    logic [31:0] key;
    logic [4:0]  count;
    logic [3:0]  wslot;
    logic [1:0]  status;
  } beam_res_t;

  typedef struct {
    bbk_pkg::op_t     op;
    logic [31:0]      key;
    logic [31:0]      payload;
    logic [3:0]       rslot;
    logic             typed;    // expected result given in the row
    bbk_pkg::status_t status;
    logic [3:0]       wslot;
    logic [4:0]       count;
  } beam_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [4:0] cfg_data = '0;
  logic cfg_ready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  always #1 clk = ~clk;

  bounded_best_k_keeper i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // predictor state
  logic [31:0] beam_keys [bbk_pkg::Depth];
  logic [31:0] beam_pays [bbk_pkg::Depth];
  logic [3:0]  beam_heap [bbk_pkg::Depth];
  logic        slot_written [bbk_pkg::Depth];
  int          pred_count;
  int          beam_cap;

  beam_res_t   due_q [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_idle = 0, recv_idle = 0;
  int          caps [6] = '{16, 1, 0, 31, 3, 7};

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void heap_swap(int a, int b);
    logic [3:0] t;
    t = beam_heap[a]; beam_heap[a] = beam_heap[b]; beam_heap[b] = t;
  endfunction

  function automatic beam_res_t beam_step(bbk_pkg::op_t op, logic [31:0] k, logic [31:0] p,
                                          logic [3:0] rs);
    beam_res_t r;
    int pos, par, l, rt, big, cap;
    logic [3:0] root;
    r = '0;
    r.status = bbk_pkg::ST_DONE;
    cap = beam_cap == 0 ? 1 : (beam_cap > bbk_pkg::Depth ? bbk_pkg::Depth : beam_cap);
    case (op)
      bbk_pkg::OP_INSERT: begin
        if (pred_count < cap) begin
          pos = pred_count;
          beam_keys[pos] = k; beam_pays[pos] = p; beam_heap[pos] = pos[3:0];
          slot_written[pos] = 1'b1;
          while (pos > 0) begin
            par = (pos - 1) / 2;
            if (beam_keys[beam_heap[par]] < beam_keys[beam_heap[pos]]) begin
              heap_swap(par, pos); pos = par;
            end else break;
          end
          r.status = bbk_pkg::ST_APPENDED; r.wslot = pred_count[3:0];
          pred_count++;
        end else begin
          root = beam_heap[0];
          if (k < beam_keys[root]) begin
            beam_keys[root] = k; beam_pays[root] = p;
            pos = 0;
            forever begin
              l = 2 * pos + 1; rt = l + 1; big = pos;
              if (l < pred_count && beam_keys[beam_heap[l]] > beam_keys[beam_heap[big]]) big = l;
              if (rt < pred_count && beam_keys[beam_heap[rt]] > beam_keys[beam_heap[big]])
                big = rt;
              if (big == pos) break;
              heap_swap(pos, big); pos = big;
            end
            r.status = bbk_pkg::ST_REPLACED; r.wslot = root;
          end else r.status = bbk_pkg::ST_REJECTED;
        end
      end
      bbk_pkg::OP_CLEAR: pred_count = 0;
      bbk_pkg::OP_READ: begin
        r.key = beam_keys[rs]; r.payload = beam_pays[rs];
      end
      default: ;
    endcase
    r.count = pred_count[4:0];
    return r;
  endfunction

  // random idling policy
  always @(posedge clk) begin
    if (!rst)
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // result checker
  always @(posedge clk) begin
    beam_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[74:0];
      if (due_q.size() == 0) begin
        report("unexpected result", 32'(got.status), 32'd0);
      end else begin
        want = due_q.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.wslot !== want.wslot)
          report("written_slot", 32'(got.wslot), 32'(want.wslot));
        if (got.count !== want.count)
          report("entry_count", 32'(got.count), 32'(want.count));
        if (got.key !== want.key) report("slot_key", got.key, want.key);
        if (got.payload !== want.payload) report("slot_payload", got.payload, want.payload);
      end
    end
  end

  // watchdog: cycles without any handshake on s_axis, m_axis or cfg
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // tvalid stays up after an accept; the next call or drain replaces or drops it
  task automatic send_item(bbk_pkg::op_t op, logic [31:0] k, logic [31:0] p, logic [3:0] rs,
                           output beam_res_t exp_r);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b0, rs, p, k, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    exp_r = beam_step(op, k, p, rs);
    due_q.push_back(exp_r);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic set_capacity(int c);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= c[4:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    beam_cap = c;
  endtask

  // random key with frequent ties and extremes
  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    beam_res_t r;
    int sel;
    logic [3:0] rs;
    bbk_pkg::op_t op;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      op = sel < 80 ? bbk_pkg::OP_INSERT : sel < 84 ? bbk_pkg::OP_CLEAR :
           sel < 96 ? bbk_pkg::OP_READ : bbk_pkg::OP_NOP;
      rs = 4'($urandom);
      // reads only hit slots that have been written
      if (op == bbk_pkg::OP_READ) begin
        int tries;
        tries = 0;
        while (!slot_written[rs] && tries < 64) begin rs = 4'($urandom); tries++; end
        if (!slot_written[rs]) op = bbk_pkg::OP_NOP;
      end
      send_item(op, rand_key(), $urandom, rs, r);
    end
  endtask

  beam_row_t dir_rows [$];

  function automatic beam_row_t mk(bbk_pkg::op_t op, logic [31:0] k, logic [31:0] p,
                                   logic [3:0] rs, logic t, bbk_pkg::status_t s,
                                   logic [3:0] w, logic [4:0] c);
    beam_row_t x;
    x.op = op; x.key = k; x.payload = p; x.rslot = rs;
    x.typed = t; x.status = s; x.wslot = w; x.count = c;
    return x;
  endfunction

  initial begin
    beam_res_t r;
    pred_count = 0;
    beam_cap = 16;
    foreach (slot_written[i]) slot_written[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: capacity 2 with ties and extremes
    dir_rows.push_back(mk(bbk_pkg::OP_NOP, 32'h0, 32'h0, 4'd0,
                          1'b1, bbk_pkg::ST_DONE, 4'd0, 5'd0));
    dir_rows.push_back(mk(bbk_pkg::OP_CLEAR, 32'h0, 32'h0, 4'd0,
                          1'b1, bbk_pkg::ST_DONE, 4'd0, 5'd0));
    dir_rows.push_back(mk(bbk_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,
                          1'b1, bbk_pkg::ST_APPENDED, 4'd0, 5'd1));
    dir_rows.push_back(mk(bbk_pkg::OP_INSERT, 32'h0001_0000, 32'h1, 4'd0,
                          1'b1, bbk_pkg::ST_APPENDED, 4'd1, 5'd2));
    dir_rows.push_back(mk(bbk_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h2, 4'd0,
                          1'b1, bbk_pkg::ST_REJECTED, 4'd0, 5'd2));
    dir_rows.push_back(mk(bbk_pkg::OP_INSERT, 32'h0001_0000, 32'h3, 4'd0,
                          1'b1, bbk_pkg::ST_REPLACED, 4'd0, 5'd2));
    dir_rows.push_back(mk(bbk_pkg::OP_INSERT, 32'h0001_0000, 32'h4, 4'd0,
                          1'b1, bbk_pkg::ST_REJECTED, 4'd0, 5'd2));
    dir_rows.push_back(mk(bbk_pkg::OP_INSERT, 32'h0, 32'h5, 4'd0,
                          1'b0, bbk_pkg::ST_DONE, 4'd0, 5'd0));
    dir_rows.push_back(mk(bbk_pkg::OP_READ, 32'h0, 32'h0, 4'd0,
                          1'b0, bbk_pkg::ST_DONE, 4'd0, 5'd0));
    dir_rows.push_back(mk(bbk_pkg::OP_READ, 32'h0, 32'h0, 4'd1,
                          1'b0, bbk_pkg::ST_DONE, 4'd0, 5'd0));
    dir_rows.push_back(mk(bbk_pkg::OP_CLEAR, 32'h0, 32'h0, 4'd0,
                          1'b1, bbk_pkg::ST_DONE, 4'd0, 5'd0));
    dir_rows.push_back(mk(bbk_pkg::OP_READ, 32'h0, 32'h0, 4'd1,
                          1'b0, bbk_pkg::ST_DONE, 4'd0, 5'd0));
    dir_rows.push_back(mk(bbk_pkg::OP_INSERT, 32'h5, 32'h6, 4'd0,
                          1'b1, bbk_pkg::ST_APPENDED, 4'd0, 5'd1));
    dir_rows.push_back(mk(bbk_pkg::OP_INSERT, 32'h9, 32'h7, 4'd0,
                          1'b1, bbk_pkg::ST_APPENDED, 4'd1, 5'd2));
    dir_rows.push_back(mk(bbk_pkg::OP_INSERT, 32'h9, 32'h8, 4'd0,
                          1'b0, bbk_pkg::ST_DONE, 4'd0, 5'd0));
    dir_rows.push_back(mk(bbk_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF,
                          1'b1, bbk_pkg::ST_DONE, 4'd0, 5'd2));

    set_capacity(2);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].payload, dir_rows[i].rslot, r);
      if (dir_rows[i].typed &&
          (r.status !== dir_rows[i].status || r.wslot !== dir_rows[i].wslot ||
           r.count !== dir_rows[i].count))
        report("directed row", i, 32'({r.status, r.wslot, r.count}));
    end

    // capacity lowered below count, then raised again
    set_capacity(1);
    send_item(bbk_pkg::OP_INSERT, 32'h1, 32'hA, 4'd0, r);
    set_capacity(16);
    for (int i = 0; i < 16; i++) send_item(bbk_pkg::OP_INSERT, rand_key(), $urandom, 4'd0, r);
    send_item(bbk_pkg::OP_READ, 32'h0, 32'h0, 4'hF, r);

    foreach (caps[i]) begin
      if (i < 2) begin send_idle = 34; recv_idle = 88; end
      else if (i < 4) begin send_idle = 88; recv_idle = 34; end
      else begin send_idle = 0; recv_idle = 0; end
      set_capacity(caps[i]);
      random_phase(300);
    end

    drain();
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

/* bounded_best_k_keeper.f */
rtl/bbk_pkg.sv
rtl/bbk_ctrl.sv
rtl/bbk_datapath.sv
rtl/bounded_best_k_keeper.sv
tb/testbench.sv
